[sv/rrtt_pkg.sv]
`default_nettype none
package rrtt_pkg;

  localparam int TAG_W         = 12;
  localparam int TAG_COUNT_DEF = 63;

  localparam logic [31:0] TIMEOUT_RST = 32'd50000000;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CPL  = 2'd2;

  localparam logic [2:0] EV_ISSUED  = 3'd0;
  localparam logic [2:0] EV_NOFREE  = 3'd1;
  localparam logic [2:0] EV_REFUSED = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             load;
    logic [TAG_W-1:0] load_tag;
    logic             step;
    logic             clear;
    logic             issue;
    logic             cpl_look;
    logic             cpl;
    logic             expire;
    logic [15:0]      cpl_tag;
    logic [63:0]      now;
    logic [31:0]      timeout;
    logic [15:0]      req;
    logic [63:0]      addr;
  } cell_ctl_t;

  // per-cell status, data zero unless the cell is selected
  typedef struct packed {
    logic        tok;
    logic        free_hit;
    logic        exp_hit;
    logic        cpl_hit;
    logic [15:0] req;
    logic [63:0] addr;
  } cell_stat_t;

endpackage
`default_nettype wire

[sv/read_request_tag_tracker.sv]
// Read request: a search token walks the cell ring one tag per cycle.
// Completion: accept, then a lookup in the completion state. Tick: a scan token walks tags
// 1..TAG_COUNT in order, with a flush state after it when any entry expires; stalls hold the token.
// One transaction in flight; the next is taken once the last result is in the output register.
// Synchronous active-low reset clears all entry valid bits, tokens, time and previous tag at once;
// the timeout register resets to 50000000. No clearing pass.
`default_nettype none
module read_request_tag_tracker #(
  parameter int TAG_COUNT = rrtt_pkg::TAG_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_req_bdf,
  input  wire logic [63:0] in_read_address,
  input  wire logic [12:0] in_read_length,
  input  wire logic        in_link_accepts,
  input  wire logic [15:0] in_completion_tag,
  input  wire logic [63:0] in_completion_data,
  input  wire logic [31:0] in_elapsed_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [11:0]      out_event_tag,
  output logic [15:0]      out_req_bdf,
  output logic [63:0]      out_address,
  output logic [12:0]      out_length,
  output logic [63:0]      out_data,
  output logic             out_last_event,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int TW = rrtt_pkg::TAG_W;
  localparam int CW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam logic [TW:0]   NT   = (TW+1)'(TAG_COUNT);
  localparam logic [CW-1:0] CEND = CW'(TAG_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CPL   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] prev_r, prev_nxt;
  logic [63:0]   now_r, now_nxt;
  logic [31:0]   tmo_r;
  logic [15:0]   req_r, ctag_r;
  logic [63:0]   addr_r, cdata_r;
  logic [12:0]   len_r;
  logic          acc_r;

  logic          pend_v_r, pend_v_nxt;
  logic [TW-1:0] pend_tag_r;
  logic [15:0]   pend_req_r;
  logic [63:0]   pend_addr_r;
  logic          pend_ld;

  logic          out_valid_r;
  logic          emit;
  logic [2:0]    e_kind;
  logic [TW-1:0] e_tag;
  logic [15:0]   e_req;
  logic [63:0]   e_addr, e_data;
  logic [12:0]   e_len;
  logic          e_last;

  rrtt_pkg::cell_ctl_t  ctl;
  rrtt_pkg::cell_stat_t stat_w [TAG_COUNT:1];
  logic [TAG_COUNT:1]   tok_w;

  logic          free_any, exp_any, cpl_any;
  logic [TW-1:0] hit_tag;
  logic [15:0]   sel_req;
  logic [63:0]   sel_addr;
  logic [TW:0]   x0, x1, x2;
  logic [TW-1:0] cand0;
  logic          in_acc, out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pready   = 1'b1;
  assign prdata   = tmo_r;

  // first candidate is ((previous tag + 1) mod TAG_COUNT) + 1, in 1..TAG_COUNT
  always_comb begin
    x0 = {1'b0, prev_r} + 1'b1;
    x1 = (x0 >= NT) ? (x0 - NT) : x0;
    x2 = (x1 >= NT) ? (x1 - NT) : x1;
    cand0 = x2[TW-1:0] + 1'b1;
  end

  for (genvar g = 1; g <= TAG_COUNT; g++) begin : g_cell
    rrtt_cell #(.ID(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tok_in ((g == 1) ? tok_w[TAG_COUNT] : tok_w[(g == 1) ? 1 : g-1]),
      .stat   (stat_w[g])
    );
    assign tok_w[g] = stat_w[g].tok;
  end

  always_comb begin
    free_any = 1'b0;
    exp_any  = 1'b0;
    cpl_any  = 1'b0;
    hit_tag  = '0;
    sel_req  = '0;
    sel_addr = '0;
    for (int i = 1; i <= TAG_COUNT; i++) begin
      free_any = free_any | stat_w[i].free_hit;
      exp_any  = exp_any  | stat_w[i].exp_hit;
      cpl_any  = cpl_any  | stat_w[i].cpl_hit;
      hit_tag  = hit_tag  | (stat_w[i].tok ? TW'(i) : '0);
      sel_req  = sel_req  | stat_w[i].req;
      sel_addr = sel_addr | stat_w[i].addr;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    now_nxt    = now_r;
    pend_v_nxt = pend_v_r;
    pend_ld    = 1'b0;
    emit       = 1'b0;
    e_kind     = rrtt_pkg::EV_ISSUED;
    e_tag      = '0;
    e_req      = req_r;
    e_addr     = addr_r;
    e_len      = len_r;
    e_data     = '0;
    e_last     = 1'b1;

    ctl          = '0;
    ctl.cpl_tag  = ctag_r;
    ctl.now      = now_r;
    ctl.timeout  = tmo_r;
    ctl.req      = req_r;
    ctl.addr     = addr_r;
    ctl.cpl_look = (state_r == S_CPL);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          case (in_cmd)
            rrtt_pkg::CMD_READ: begin
              ctl.load     = 1'b1;
              ctl.load_tag = cand0;
              state_nxt    = S_SRCH;
            end
            rrtt_pkg::CMD_CPL: begin
              state_nxt = S_CPL;
            end
            rrtt_pkg::CMD_TICK: begin
              now_nxt      = now_r + {32'h0, in_elapsed_time};
              ctl.load     = 1'b1;
              ctl.load_tag = TW'(1);
              state_nxt    = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (free_any) begin
          if (out_free) begin
            emit      = 1'b1;
            e_tag     = hit_tag;
            e_kind    = acc_r ? rrtt_pkg::EV_ISSUED : rrtt_pkg::EV_REFUSED;
            ctl.issue = acc_r;
            ctl.clear = 1'b1;
            if (acc_r) begin
              prev_nxt = hit_tag;
            end
            state_nxt = S_IDLE;
          end
        end else if (cnt_r == CEND) begin
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = rrtt_pkg::EV_NOFREE;
            ctl.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_CPL: begin
        if (!cpl_any) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          e_kind    = rrtt_pkg::EV_DONE;
          e_tag     = ctag_r[TW-1:0];
          e_req     = sel_req;
          e_addr    = sel_addr;
          e_len     = '0;
          e_data    = cdata_r;
          ctl.cpl   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // hold the token while a found entry can't be buffered
        if (!(exp_any && pend_v_r && !out_free)) begin
          if (exp_any) begin
            ctl.expire = 1'b1;
            pend_ld    = 1'b1;
            pend_v_nxt = 1'b1;
            if (pend_v_r) begin
              emit   = 1'b1;
              e_last = 1'b0;
            end
          end
          if (cnt_r == CEND) begin
            ctl.clear = 1'b1;
            state_nxt = (pend_v_r || exp_any) ? S_FLUSH : S_IDLE;
          end else begin
            ctl.step = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        if (emit) begin
          e_kind = rrtt_pkg::EV_TIMEOUT;
          e_tag  = pend_tag_r;
          e_req  = pend_req_r;
          e_addr = pend_addr_r;
          e_len  = '0;
        end
      end
      S_FLUSH: begin
        e_kind = rrtt_pkg::EV_TIMEOUT;
        e_tag  = pend_tag_r;
        e_req  = pend_req_r;
        e_addr = pend_addr_r;
        e_len  = '0;
        if (out_free) begin
          emit       = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      now_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tmo_r       <= rrtt_pkg::TIMEOUT_RST;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      prev_r   <= prev_nxt;
      now_r    <= now_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && (paddr[2] == rrtt_pkg::REG_TIMEOUT)) begin
        tmo_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_req_bdf;
      addr_r  <= in_read_address;
      len_r   <= in_read_length;
      acc_r   <= in_link_accepts;
      ctag_r  <= in_completion_tag;
      cdata_r <= in_completion_data;
    end
    if (pend_ld) begin
      pend_tag_r  <= hit_tag;
      pend_req_r  <= sel_req;
      pend_addr_r <= sel_addr;
    end
    if (emit) begin
      out_event_kind <= e_kind;
      out_event_tag  <= e_tag;
      out_req_bdf    <= e_req;
      out_address    <= e_addr;
      out_length     <= e_len;
      out_data       <= e_data;
      out_last_event <= e_last;
    end
  end

  assign out_valid = out_valid_r;

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_w)) else $error("more than one token in the cell ring");

  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_SCAN || state_r == S_FLUSH))
    else $error("pending timeout outside a scan");

  a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, prev_r} <= NT)) else $error("previous tag out of range");

  a_busy_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_SCAN) |-> (tok_w != '0))
    else $error("search or scan without a token");

endmodule
`default_nettype wire

[sv/rrtt_cell.sv]
`default_nettype none
module rrtt_cell #(
  parameter int ID = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrtt_pkg::cell_ctl_t ctl,
  input  wire logic               tok_in,
  output rrtt_pkg::cell_stat_t    stat
);

  logic        valid_r, valid_nxt;
  logic        tok_r, tok_nxt;
  logic [63:0] issue_r;
  logic [31:0] tmo_r;
  logic [15:0] req_r;
  logic [63:0] addr_r;
  logic        free_hit, exp_hit, cpl_hit, expired;

  assign expired  = valid_r && ((ctl.now - issue_r) >= {32'h0, tmo_r});
  assign free_hit = tok_r && !valid_r;
  assign exp_hit  = tok_r && expired;
  assign cpl_hit  = ctl.cpl_look && valid_r && (ctl.cpl_tag == 16'(ID));

  always_comb begin
    if (ctl.clear) begin
      tok_nxt = 1'b0;
    end else if (ctl.load) begin
      tok_nxt = (ctl.load_tag == rrtt_pkg::TAG_W'(ID));
    end else if (ctl.step) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
    valid_nxt = valid_r;
    if (ctl.issue && free_hit) begin
      valid_nxt = 1'b1;
    end else if ((ctl.cpl && cpl_hit) || (ctl.expire && exp_hit)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue && free_hit) begin
      issue_r <= ctl.now;
      tmo_r   <= ctl.timeout;
      req_r   <= ctl.req;
      addr_r  <= ctl.addr;
    end
  end

  always_comb begin
    stat.tok      = tok_r;
    stat.free_hit = free_hit;
    stat.exp_hit  = exp_hit;
    stat.cpl_hit  = cpl_hit;
    stat.req      = (tok_r || cpl_hit) ? req_r : 16'h0;
    stat.addr     = (tok_r || cpl_hit) ? addr_r : 64'h0;
  end

endmodule
`default_nettype wire

[tb/sv/read_request_tag_tracker_tb.sv]
`default_nettype none
module read_request_tag_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAGS = rrtt_pkg::TAG_COUNT_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] rid;
    logic [63:0] addr;
    logic [12:0] len;
    logic        accepts;
    logic [15:0] ctag;
    logic [63:0] cdata;
    logic [31:0] elapsed;
  } req_txn_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] tag;
    logic [15:0] rid;
    logic [63:0] addr;
    logic [12:0] len;
    logic [63:0] data;
    logic        last;
  } event_txn_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = '0;
  logic [15:0] in_req_bdf = '0;
  logic [63:0] in_read_address = '0;
  logic [12:0] in_read_length = '0;
  logic in_link_accepts = 1'b0;
  logic [15:0] in_completion_tag = '0;
  logic [63:0] in_completion_data = '0;
  logic [31:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_event_kind;
  logic [11:0] out_event_tag;
  logic [15:0] out_req_bdf;
  logic [63:0] out_address;
  logic [12:0] out_length;
  logic [63:0] out_data;
  logic out_last_event;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  read_request_tag_tracker dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker mirror
  logic [31:0] tmo_reg;
  logic        tag_busy [1:NTAGS];
  logic [63:0] tag_issued_at [1:NTAGS];
  logic [15:0] tag_rid [1:NTAGS];
  logic [63:0] tag_addr [1:NTAGS];
  logic [31:0] tag_tmo [1:NTAGS];
  int          last_tag;
  logic [63:0] now_ns;

  req_txn_t   pending_reqs[$];
  event_txn_t expected_events[$];
  int errors = 0;
  int cycles = 0;
  int n_issued = 0, n_timeouts = 0, n_events = 0;
  int hold_off = 0;
  int sink_stall = 0;
  logic in_taken = 1'b0;

  function automatic void queue_req(req_txn_t t);
    pending_reqs = {pending_reqs, t};
  endfunction

  function automatic void expect_event(event_txn_t e);
    expected_events = {expected_events, e};
  endfunction

  function automatic event_txn_t mk_event(logic [2:0] k, int tag, logic [15:0] rid,
                                          logic [63:0] a, logic [12:0] l,
                                          logic [63:0] d, logic last);
    event_txn_t e;
    e.kind = k; e.tag = tag[11:0]; e.rid = rid; e.addr = a; e.len = l;
    e.data = d; e.last = last;
    return e;
  endfunction

  function automatic int free_tag_search();
    int cand;
    for (int i = 1; i <= NTAGS; i++) begin
      cand = ((last_tag + i) % NTAGS) + 1;
      if (!tag_busy[cand]) return cand;
    end
    return 0;
  endfunction

  task automatic predict_tracker(req_txn_t t);
    int tag, first, cnt;
    case (t.cmd)
      rrtt_pkg::CMD_READ: begin
        tag = free_tag_search();
        if (tag == 0) begin
          expect_event(mk_event(rrtt_pkg::EV_NOFREE, 0, t.rid, t.addr, t.len, '0, 1'b1));
        end else if (!t.accepts) begin
          expect_event(mk_event(rrtt_pkg::EV_REFUSED, tag, t.rid, t.addr, t.len, '0, 1'b1));
        end else begin
          last_tag = tag;
          tag_busy[tag] = 1'b1;
          tag_issued_at[tag] = now_ns;
          tag_rid[tag] = t.rid;
          tag_addr[tag] = t.addr;
          tag_tmo[tag] = tmo_reg;
          n_issued++;
          expect_event(mk_event(rrtt_pkg::EV_ISSUED, tag, t.rid, t.addr, t.len, '0, 1'b1));
        end
      end
      rrtt_pkg::CMD_CPL: begin
        if (t.ctag != 0 && t.ctag <= NTAGS && tag_busy[t.ctag]) begin
          tag_busy[t.ctag] = 1'b0;
          expect_event(mk_event(rrtt_pkg::EV_DONE, t.ctag, tag_rid[t.ctag],
                                tag_addr[t.ctag], '0, t.cdata, 1'b1));
        end
      end
      rrtt_pkg::CMD_TICK: begin
        now_ns = now_ns + 64'(t.elapsed);
        first = expected_events.size();
        cnt = 0;
        for (int g = 1; g <= NTAGS; g++) begin
          if (tag_busy[g] && (now_ns - tag_issued_at[g]) >= 64'(tag_tmo[g])) begin
            tag_busy[g] = 1'b0;
            expect_event(mk_event(rrtt_pkg::EV_TIMEOUT, g, tag_rid[g], tag_addr[g],
                                  '0, '0, 1'b0));
            cnt++;
            n_timeouts++;
          end
        end
        if (cnt > 0) expected_events[first + cnt - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_tracker(pending_reqs.pop_front());
        hold_off = gap_len();
      end
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() > 0 && hold_off == 0) begin
          in_valid <= 1'b1;
          in_cmd <= pending_reqs[0].cmd;
          in_req_bdf <= pending_reqs[0].rid;
          in_read_address <= pending_reqs[0].addr;
          in_read_length <= pending_reqs[0].len;
          in_link_accepts <= pending_reqs[0].accepts;
          in_completion_tag <= pending_reqs[0].ctag;
          in_completion_data <= pending_reqs[0].cdata;
          in_elapsed_time <= pending_reqs[0].elapsed;
        end else begin
          in_valid <= 1'b0;
          if (hold_off > 0) hold_off--;
        end
      end
    end
  end

  // sink readiness
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      sink_stall = gap_len();
      out_ready <= (sink_stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    event_txn_t e;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      n_events++;
      if (expected_events.size() == 0) begin
        $error("unexpected event kind=%0d tag=%0d", out_event_kind, out_event_tag);
        errors++;
      end else begin
        e = expected_events.pop_front();
        if (out_event_kind !== e.kind) begin
          $error("event_kind exp %0d got %0d", e.kind, out_event_kind); errors++;
        end
        if (out_event_tag !== e.tag) begin
          $error("event_tag exp %0d got %0d", e.tag, out_event_tag); errors++;
        end
        if (out_req_bdf !== e.rid) begin
          $error("req_bdf exp %h got %h", e.rid, out_req_bdf); errors++;
        end
        if (out_address !== e.addr) begin
          $error("address exp %h got %h", e.addr, out_address); errors++;
        end
        if (out_length !== e.len) begin
          $error("length exp %0d got %0d", e.len, out_length); errors++;
        end
        if (out_data !== e.data) begin
          $error("data exp %h got %h", e.data, out_data); errors++;
        end
        if (out_last_event !== e.last) begin
          $error("last_event exp %0d got %0d", e.last, out_last_event); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_txn_t rand_req(logic [1:0] cmd);
    req_txn_t t;
    t.cmd = cmd;
    t.rid = 16'($urandom());
    t.addr = {$urandom(), $urandom()};
    t.len = 13'($urandom_range(0, 4096));
    t.accepts = ($urandom_range(0, 5) != 0);
    t.ctag = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, NTAGS + 1));
    t.cdata = {$urandom(), $urandom()};
    t.elapsed = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 400);
    return t;
  endfunction

  task automatic apb_write_timeout(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(rrtt_pkg::REG_TIMEOUT) * 3'd4; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tmo_reg = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (prdata !== v) begin
      $error("completion_timeout exp %h got %h", v, prdata); errors++;
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (NTAGS + 10) @(posedge clk);
  endtask

  initial begin
    req_txn_t t;
    int k;
    tmo_reg = rrtt_pkg::TIMEOUT_RST;
    for (int g = 1; g <= NTAGS; g++) tag_busy[g] = 1'b0;
    last_tag = 0;
    now_ns = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: short timeout, short tick
    apb_write_timeout(32'd100);
    t = rand_req(rrtt_pkg::CMD_READ); t.rid = '1; t.addr = '1; t.len = 13'd4096; t.accepts = 1;
    queue_req(t);
    t = rand_req(rrtt_pkg::CMD_READ); t.rid = '0; t.addr = '0; t.len = 13'd0; t.accepts = 0;
    queue_req(t);
    t = rand_req(rrtt_pkg::CMD_CPL); t.ctag = 16'd1; t.cdata = '1; queue_req(t);
    t = rand_req(rrtt_pkg::CMD_CPL); t.ctag = 16'd1; queue_req(t);
    t = rand_req(rrtt_pkg::CMD_CPL); t.ctag = 16'd0; queue_req(t);
    t = rand_req(rrtt_pkg::CMD_CPL); t.ctag = 16'hFFFF; queue_req(t);
    t = rand_req(CMD_BAD); queue_req(t);
    for (int i = 0; i < 3; i++) begin
      t = rand_req(rrtt_pkg::CMD_READ); t.accepts = 1; queue_req(t);
    end
    t = rand_req(rrtt_pkg::CMD_TICK); t.elapsed = 32'd0; queue_req(t);
    t = rand_req(rrtt_pkg::CMD_TICK); t.elapsed = 32'd100; queue_req(t);
    drain();

    // fill every tag, then no-free-tag, then mass timeout
    apb_write_timeout(32'hFFFF_FFFF);
    for (int i = 0; i < NTAGS + 2; i++) begin
      t = rand_req(rrtt_pkg::CMD_READ); t.accepts = 1; queue_req(t);
    end
    t = rand_req(rrtt_pkg::CMD_TICK); t.elapsed = 32'hFFFF_FFFF; queue_req(t);
    t = rand_req(rrtt_pkg::CMD_TICK); t.elapsed = 32'hFFFF_FFFF; queue_req(t);
    drain();

    // random phases, timeout extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apb_write_timeout(32'd0);
        1: apb_write_timeout(32'd500);
        2: apb_write_timeout($urandom_range(50, 3000));
        default: apb_write_timeout(rrtt_pkg::TIMEOUT_RST);
      endcase
      for (int i = 0; i < 58; i++) begin
        k = $urandom_range(0, 99);
        if (k < 50) t = rand_req(rrtt_pkg::CMD_READ);
        else if (k < 80) begin
          t = rand_req(rrtt_pkg::CMD_CPL);
        end else if (k < 97) t = rand_req(rrtt_pkg::CMD_TICK);
        else t = rand_req(CMD_BAD);
        queue_req(t);
      end
      drain();
    end

    $display("covered %0d issues, %0d timeouts, %0d events checked in %0d cycles",
             n_issued, n_timeouts, n_events, cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
